// ===== src/vra_pkg.sv =====
package vra_pkg;

    // Table geometry and page size
    localparam int MAX_REGIONS = 256;
    localparam int PAGE_BYTES  = 4096;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int IDX_W       = $clog2(MAX_REGIONS);
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

    // Field widths
    localparam int ADDR_W  = 32;
    localparam int PAGES_W = 21;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_LENGTH = 1'd1;

    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC   = 2'd0,
        FN_RELEASE = 2'd1,
        FN_CHECK   = 2'd2,
        FN_NONE    = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        STS_OK        = 2'd0,
        STS_ZERO      = 2'd1,
        STS_FULL      = 2'd2,
        STS_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC_RD,
        ST_ALLOC_WR,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } t_state;

    // One table entry
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
    } t_entry;

    // Region table access, one read and one write per cycle
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
    } t_ram_req;

    // One result beat
    typedef struct packed {
        logic          legit;
        t_status       status;
        logic [PAGES_W-1:0] pages;
        logic [ADDR_W-1:0]  addr;
    } t_result;

endpackage

// ===== src/vra_region_ram.sv =====
module vra_region_ram (
    input  logic              i_clk,
    input  vra_pkg::t_ram_req i_req,
    output vra_pkg::t_entry   o_rd_data
);

    vra_pkg::t_entry r_mem [vra_pkg::MAX_REGIONS];
    vra_pkg::t_entry r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/vra_ctrl.sv =====
module vra_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request side
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [vra_pkg::FUNC_W-1:0]    i_func,
    input  logic [vra_pkg::ADDR_W-1:0]    i_request_bytes,
    input  logic [vra_pkg::ADDR_W-1:0]    i_query_address,
    // pool setup
    input  logic [vra_pkg::ADDR_W-1:0]    i_pool_base,
    input  logic [vra_pkg::ADDR_W-1:0]    i_pool_length,
    // result side
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output vra_pkg::t_result              o_res,
    // region table
    output vra_pkg::t_ram_req             o_ram_req,
    input  vra_pkg::t_entry               i_rd_data
);

    vra_pkg::t_state r_state, n_state;

    logic [vra_pkg::CNT_W-1:0]   r_count;
    logic [vra_pkg::CNT_W-1:0]   r_idx;
    logic                        r_chk_v;
    logic [vra_pkg::IDX_W-1:0]   r_chk_idx;
    logic                        r_sh_v;
    logic [vra_pkg::IDX_W-1:0]   r_sh_idx;
    logic [vra_pkg::ADDR_W-1:0]  r_query;
    logic [vra_pkg::PAGES_W-1:0] r_pages;
    vra_pkg::t_result            r_res;

    logic                        accept;
    logic                        full;
    logic                        issue_scan;
    logic                        hit;
    logic                        scan_miss_end;
    logic                        issue_shift;
    logic                        shift_done;
    logic [vra_pkg::ADDR_W:0]    round_sum;
    logic [vra_pkg::PAGES_W-1:0] req_pages;
    logic [vra_pkg::ADDR_W-1:0]  alloc_start;
    logic [vra_pkg::ADDR_W-1:0]  alloc_size;
    logic [vra_pkg::ADDR_W:0]    pool_top;
    vra_pkg::t_result            imm_res;
    vra_pkg::t_result            hit_res;

    assign accept     = i_in_valid && (r_state == vra_pkg::ST_IDLE);
    assign o_in_ready = (r_state == vra_pkg::ST_IDLE);
    assign full       = (r_count == vra_pkg::CNT_W'(vra_pkg::MAX_REGIONS));

    // Page rounding of the request
    assign round_sum = {1'b0, i_request_bytes} + (vra_pkg::ADDR_W+1)'(vra_pkg::PAGE_BYTES - 1);
    assign req_pages = vra_pkg::PAGES_W'(round_sum >> vra_pkg::PAGE_SHIFT);

    // New region goes right after the last entry, or one page above the pool base when the table is empty
    assign alloc_size  = vra_pkg::ADDR_W'({r_pages, {vra_pkg::PAGE_SHIFT{1'b0}}});
    assign alloc_start = (r_count == '0)
                       ? i_pool_base + vra_pkg::ADDR_W'(vra_pkg::PAGE_BYTES)
                       : i_rd_data.start + i_rd_data.size;

    // Search and shift control
    assign issue_scan    = (r_state == vra_pkg::ST_SCAN) && (r_idx < r_count);
    assign hit           = (r_state == vra_pkg::ST_SCAN) && r_chk_v
                           && (i_rd_data.start == r_query);
    assign scan_miss_end = (r_state == vra_pkg::ST_SCAN) && r_chk_v && !hit
                           && ({1'b0, r_chk_idx} == r_count - vra_pkg::CNT_W'(1));
    assign issue_shift   = (r_state == vra_pkg::ST_SHIFT)
                           && ((r_idx + vra_pkg::CNT_W'(1)) < r_count);
    assign shift_done    = (r_state == vra_pkg::ST_SHIFT) && !issue_shift && !r_sh_v;

    assign pool_top = {1'b0, i_pool_base} + {1'b0, i_pool_length};

    // Results known at accept time
    always_comb begin
        imm_res        = '0;
        imm_res.status = vra_pkg::STS_OK;
        unique case (vra_pkg::t_func'(i_func))
            vra_pkg::FN_ALLOC: begin
                if (i_request_bytes == '0) begin
                    imm_res.status = vra_pkg::STS_ZERO;
                end else if (full) begin
                    imm_res.status = vra_pkg::STS_FULL;
                end
            end
            vra_pkg::FN_RELEASE: begin
                imm_res.status = vra_pkg::STS_NOT_FOUND;
            end
            vra_pkg::FN_CHECK: begin
                imm_res.legit = (i_query_address >= i_pool_base)
                                && ({1'b0, i_query_address} < pool_top);
            end
            default: begin
                imm_res = '0;
            end
        endcase
    end

    always_comb begin
        hit_res        = '0;
        hit_res.addr   = i_rd_data.start;
        hit_res.pages  = vra_pkg::PAGES_W'(i_rd_data.size >> vra_pkg::PAGE_SHIFT);
        hit_res.status = vra_pkg::STS_OK;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vra_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = vra_pkg::ST_DONE;
                    if (vra_pkg::t_func'(i_func) == vra_pkg::FN_ALLOC
                        && i_request_bytes != '0 && !full) begin
                        n_state = vra_pkg::ST_ALLOC_RD;
                    end else if (vra_pkg::t_func'(i_func) == vra_pkg::FN_RELEASE
                                 && r_count != '0) begin
                        n_state = vra_pkg::ST_SCAN;
                    end
                end
            end
            vra_pkg::ST_ALLOC_RD: n_state = vra_pkg::ST_ALLOC_WR;
            vra_pkg::ST_ALLOC_WR: n_state = vra_pkg::ST_DONE;
            vra_pkg::ST_SCAN: begin
                if (hit) begin
                    n_state = vra_pkg::ST_SHIFT;
                end else if (scan_miss_end) begin
                    n_state = vra_pkg::ST_DONE;
                end
            end
            vra_pkg::ST_SHIFT: begin
                if (shift_done) begin
                    n_state = vra_pkg::ST_DONE;
                end
            end
            vra_pkg::ST_DONE: begin
                if (i_res_ready) begin
                    n_state = vra_pkg::ST_IDLE;
                end
            end
            default: n_state = vra_pkg::ST_IDLE;
        endcase
    end

    // Table accesses per state
    always_comb begin
        o_ram_req = '0;
        unique case (r_state)
            vra_pkg::ST_ALLOC_RD: begin
                o_ram_req.rd_en   = 1'b1;
                o_ram_req.rd_addr = vra_pkg::IDX_W'(r_count - vra_pkg::CNT_W'(1));
            end
            vra_pkg::ST_ALLOC_WR: begin
                o_ram_req.wr_en         = 1'b1;
                o_ram_req.wr_addr       = r_count[vra_pkg::IDX_W-1:0];
                o_ram_req.wr_data.start = alloc_start;
                o_ram_req.wr_data.size  = alloc_size;
            end
            vra_pkg::ST_SCAN: begin
                o_ram_req.rd_en   = issue_scan;
                o_ram_req.rd_addr = r_idx[vra_pkg::IDX_W-1:0];
            end
            vra_pkg::ST_SHIFT: begin
                o_ram_req.rd_en   = issue_shift;
                o_ram_req.rd_addr = r_idx[vra_pkg::IDX_W-1:0] + vra_pkg::IDX_W'(1);
                o_ram_req.wr_en   = r_sh_v;
                o_ram_req.wr_addr = r_sh_idx;
                o_ram_req.wr_data = i_rd_data;
            end
            default: o_ram_req = '0;
        endcase
    end

    assign o_res_valid = (r_state == vra_pkg::ST_DONE);
    assign o_res       = r_res;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vra_pkg::ST_IDLE;
            r_count <= '0;
            r_chk_v <= 1'b0;
            r_sh_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_chk_v <= 1'b0;
                r_sh_v  <= 1'b0;
            end
            if (r_state == vra_pkg::ST_ALLOC_WR) begin
                r_count <= r_count + vra_pkg::CNT_W'(1);
            end
            if (r_state == vra_pkg::ST_SCAN) begin
                r_chk_v <= issue_scan;
                r_sh_v  <= 1'b0;
            end
            if (r_state == vra_pkg::ST_SHIFT) begin
                r_sh_v <= issue_shift;
            end
            if (shift_done) begin
                r_count <= r_count - vra_pkg::CNT_W'(1);
            end
        end
    end

    // Payload and index registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_query <= i_query_address;
            r_pages <= req_pages;
            r_idx   <= '0;
            r_res   <= imm_res;
        end
        if (r_state == vra_pkg::ST_ALLOC_WR) begin
            r_res.addr   <= alloc_start;
            r_res.pages  <= r_pages;
            r_res.status <= vra_pkg::STS_OK;
            r_res.legit  <= 1'b0;
        end
        if (r_state == vra_pkg::ST_SCAN) begin
            r_chk_idx <= r_idx[vra_pkg::IDX_W-1:0];
            // a miss keeps the not-found result taken at accept
            if (hit) begin
                r_res <= hit_res;
                r_idx <= {1'b0, r_chk_idx};
            end else if (issue_scan) begin
                r_idx <= r_idx + vra_pkg::CNT_W'(1);
            end
        end
        if (r_state == vra_pkg::ST_SHIFT) begin
            r_sh_idx <= r_idx[vra_pkg::IDX_W-1:0];
            if (issue_shift) begin
                r_idx <= r_idx + vra_pkg::CNT_W'(1);
            end
        end
    end

endmodule

// ===== src/virtual_region_allocator_unit.sv =====
// Virtual region allocator: bump allocator over an ordered region table.
// Configuration: write i_cfg_data to register i_cfg_idx (0 pool base,
// 1 pool length) with i_cfg_we, only while the block is idle.
// Request channel (i_s_*): one beat per operation; tuser carries the
// operation (allocate, release, check), tdata the request size and the
// query address. Result channel (o_m_*): exactly one beat per request
// with region address, page count, status and the in-pool flag.
// From accept to the load of the output register: check, zero-size, full,
// unknown operations and release on an empty table go straight to done;
// allocate reads the last entry, then writes the new one; release searches
// the table and on a hit shifts the later entries down, using the single
// table read port: the search reads one entry a cycle up to the match,
// the shift then moves one entry a cycle down to the end of the table.
// One request is in work at a time; the next is taken as soon as the
// result has moved into the output register, even if that beat is stalled.
// While the receiver holds tready low the result beat stays unchanged and
// a finished following result waits inside the controller.
// Reset empties the table (count 0) and clears both pool registers; the
// table memory itself is not cleared and needs no clearing pass.
module virtual_region_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // request_bytes[31:0], query_address[63:32]
    input  logic [1:0]  i_s_tuser,   // func[1:0]
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata    // region_address[31:0], region_pages[52:32],
                                     // status[54:53], legitimate[55]
);

    logic [vra_pkg::ADDR_W-1:0] r_pool_base;
    logic [vra_pkg::ADDR_W-1:0] r_pool_length;
    logic                       r_m_valid;
    vra_pkg::t_result           r_m_res;

    logic                       res_valid;
    logic                       res_ready;
    vra_pkg::t_result           res;
    vra_pkg::t_ram_req          ram_req;
    vra_pkg::t_entry            rd_data;

    // Pool registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base   <= '0;
            r_pool_length <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vra_pkg::CFG_POOL_BASE:   r_pool_base   <= i_cfg_data;
                vra_pkg::CFG_POOL_LENGTH: r_pool_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    vra_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_s_tvalid),
        .o_in_ready      (o_s_tready),
        .i_func          (i_s_tuser),
        .i_request_bytes (i_s_tdata[31:0]),
        .i_query_address (i_s_tdata[63:32]),
        .i_pool_base     (r_pool_base),
        .i_pool_length   (r_pool_length),
        .o_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .o_res           (res),
        .o_ram_req       (ram_req),
        .i_rd_data       (rd_data)
    );

    vra_region_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    // Output register
    assign res_ready = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_m_res <= res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_res;

endmodule

// ===== src/vra_checker.sv =====
module vra_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [55:0] o_m_tdata
);

    // Stalled result beat stays
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result beat changed while stalled");

    // Error statuses carry no region
    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[54:53] != 2'd0) |-> (o_m_tdata[52:0] == '0)
                                                     && !o_m_tdata[55])
        else $error("error status with region data");

    // In-pool flag only comes from a check, which reports no region
    a_legit_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[55] |-> (o_m_tdata[54:0] == '0))
        else $error("in-pool flag with region data");

    // No result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind virtual_region_allocator_unit vra_checker u_vra_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
